FILE: hdl/cem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cem_pkg
// Shared types and constants of the cosine embedding match block.
// ----------------------------------------------------------------------------
package cem_pkg;

  localparam int VECTOR_LEN  = 512;
  localparam int POS_W       = 9;
  localparam int MAX_ENTRIES = 256;
  localparam int ENTRY_W     = 8;
  localparam int ELEM_W      = 16;
  localparam int GAL_DEPTH   = MAX_ENTRIES * VECTOR_LEN;
  localparam int GAL_AW      = ENTRY_W + POS_W;
  localparam int COUNT_W     = 9;
  localparam int DOT_W       = 41;
  localparam int NORM_W      = 40;
  localparam int SIM_W       = 16;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic FUNC_GALLERY = 1'b0;
  localparam logic FUNC_QUERY   = 1'b1;

  localparam logic signed [SIM_W-1:0] SIM_NONE = 16'sh8000;
  localparam logic signed [SIM_W-1:0] SIM_MAX  = 16'sh7fff;

  typedef struct packed {
    logic                     func;
    logic                     last;
    logic [ENTRY_W-1:0]       entry;
    logic [POS_W-1:0]         position;
    logic signed [ELEM_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/cem_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cem_front
// Accepts input beats, unpacks them into commands and queues them.
// ----------------------------------------------------------------------------
module cem_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // entry [7:0], position [16:8], value [32:17], zero padding above
  input  wire logic [cem_pkg::IN_DATA_W-1:0]      s_tdata,
  // func [0]
  input  wire logic                               s_tuser,
  input  wire logic                               s_tlast,
  input  wire logic                               pop,
  output logic                                    cmd_valid,
  output cem_pkg::cmd_t                           cmd
);

  cem_pkg::cmd_t                   queue [cem_pkg::QUEUE_DEPTH];
  logic [cem_pkg::QUEUE_AW-1:0]    wptr;
  logic [cem_pkg::QUEUE_AW-1:0]    rptr;
  logic [cem_pkg::QUEUE_AW:0]      fill;
  cem_pkg::cmd_t                   decoded;
  logic                            push;
  logic                            take;

  always_comb begin
    decoded.func     = s_tuser;
    decoded.last     = s_tlast;
    decoded.entry    = s_tdata[7:0];
    decoded.position = s_tdata[16:8];
    decoded.value    = s_tdata[32:17];
  end

  assign s_tready  = (fill != (cem_pkg::QUEUE_AW+1)'(cem_pkg::QUEUE_DEPTH));
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (fill != '0);
  assign take      = pop && cmd_valid;
  assign cmd       = queue[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !take) begin
        fill <= fill + 1'b1;
      end else if (take && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cem_score.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cem_score
// Turns a dot product and two squared norms into a Q1.15 cosine similarity
// with a shift-add multiplier and a bit-by-bit square root search.
// ----------------------------------------------------------------------------
module cem_score (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic signed [cem_pkg::DOT_W-1:0]       dot,
  input  wire logic [cem_pkg::NORM_W-1:0]             nq,
  input  wire logic [cem_pkg::NORM_W-1:0]             ng,
  output logic                                        done,
  output logic signed [cem_pkg::SIM_W-1:0]            sim
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int PW = 2 * cem_pkg::NORM_W;
  localparam int WW = 112;

  logic [2:0]                     state;
  logic [5:0]                     cnt;
  logic [PW-1:0]                  acc;
  logic [PW-1:0]                  acc_next;
  logic [PW-1:0]                  ma;
  logic [cem_pkg::NORM_W-1:0]     mb;
  logic [cem_pkg::NORM_W-1:0]     mag;
  logic [PW-1:0]                  prod;
  logic [WW-1:0]                  target;
  logic [WW-1:0]                  r2p;
  logic [WW-1:0]                  q;
  logic [WW-1:0]                  pk2;
  logic [WW-1:0]                  trial;
  logic [15:0]                    r;
  logic [3:0]                     k;
  logic                           neg;
  logic signed [cem_pkg::DOT_W-1:0] dot_abs;

  assign dot_abs  = dot[cem_pkg::DOT_W-1] ? -dot : dot;
  assign mag      = dot_abs[cem_pkg::NORM_W-1:0];
  assign acc_next = mb[0] ? acc + ma : acc;
  assign trial    = r2p + q + pk2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (nq == '0 || ng == '0) begin
              sim  <= cem_pkg::SIM_NONE;
              done <= 1'b1;
            end else begin
              neg   <= dot[cem_pkg::DOT_W-1];
              ma    <= PW'(nq);
              mb    <= ng;
              acc   <= '0;
              cnt   <= '0;
              state <= S_MUL1;
            end
          end
        end
        S_MUL1, S_MUL2: begin
          acc <= acc_next;
          ma  <= ma << 1;
          mb  <= mb >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == 6'(cem_pkg::NORM_W - 1)) begin
            cnt <= '0;
            acc <= '0;
            if (state == S_MUL1) begin
              prod  <= acc_next;
              ma    <= PW'(mag);
              mb    <= mag;
              state <= S_MUL2;
            end else begin
              target <= WW'({acc_next, 30'b0});
              pk2    <= {2'b0, prod, 30'b0};
              q      <= '0;
              r2p    <= '0;
              r      <= '0;
              k      <= 4'd15;
              state  <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (trial <= target) begin
            r2p  <= trial;
            q    <= (q + (pk2 << 1)) >> 1;
            r[k] <= 1'b1;
          end else begin
            q <= q >> 1;
          end
          pk2 <= pk2 >> 2;
          if (k == 4'd0) begin
            state <= S_FIN;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_FIN: begin
          if (neg) begin
            sim <= -$signed({1'b0, r[14:0]}) - $signed({r[15], 15'b0});
          end else if (r[15]) begin
            sim <= cem_pkg::SIM_MAX;
          end else begin
            sim <= $signed(r);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cem_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cem_back
// Holds the gallery and query memories, runs the search over the gallery
// and keeps the result beat until it is taken.
// ----------------------------------------------------------------------------
module cem_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cmd_valid,
  input  wire cem_pkg::cmd_t                         cmd,
  output logic                                       pop,
  input  wire logic [cem_pkg::COUNT_W-1:0]           entry_count,
  input  wire logic signed [cem_pkg::SIM_W-1:0]      match_threshold,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // match_index [7:0], best_similarity [23:8]
  output logic [cem_pkg::OUT_DATA_W-1:0]             m_tdata,
  // found [0], matched [1]
  output logic [1:0]                                 m_tuser
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_SCORE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic signed [cem_pkg::ELEM_W-1:0] gallery [cem_pkg::GAL_DEPTH];
  logic signed [cem_pkg::ELEM_W-1:0] query_buffer [cem_pkg::VECTOR_LEN];

  logic [2:0]                          state;
  logic [cem_pkg::POS_W:0]             idx;
  logic [cem_pkg::COUNT_W-1:0]         ent;
  logic [cem_pkg::COUNT_W-1:0]         count;
  logic                                rd_en;
  logic                                v1;
  logic                                v2;
  logic signed [cem_pkg::ELEM_W-1:0]   qd;
  logic signed [cem_pkg::ELEM_W-1:0]   gd;
  logic signed [31:0]                  p_qg;
  logic signed [31:0]                  p_gg;
  logic signed [31:0]                  p_qq;
  logic signed [cem_pkg::DOT_W-1:0]    dot;
  logic [cem_pkg::NORM_W-1:0]          nq;
  logic [cem_pkg::NORM_W-1:0]          ng;
  logic                                score_start;
  logic                                score_done;
  logic signed [cem_pkg::SIM_W-1:0]    sim;
  logic signed [cem_pkg::SIM_W-1:0]    best;
  logic [cem_pkg::ENTRY_W-1:0]         best_idx;
  logic                                found;
  logic                                load_out;
  logic                                gal_we;
  logic                                qry_we;

  assign count = (entry_count > cem_pkg::COUNT_W'(cem_pkg::MAX_ENTRIES))
               ? cem_pkg::COUNT_W'(cem_pkg::MAX_ENTRIES) : entry_count;
  assign pop         = (state == ST_IDLE) && cmd_valid;
  assign gal_we      = pop && (cmd.func == cem_pkg::FUNC_GALLERY);
  assign qry_we      = pop && (cmd.func == cem_pkg::FUNC_QUERY);
  assign rd_en       = (state == ST_RUN);
  assign score_start = (state == ST_WAIT) && !v1 && !v2;
  assign load_out    = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (gal_we) begin
      gallery[{cmd.entry, cmd.position}] <= cmd.value;
    end
    if (rd_en) begin
      gd <= gallery[{ent[cem_pkg::ENTRY_W-1:0], idx[cem_pkg::POS_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (qry_we) begin
      query_buffer[cmd.position] <= cmd.value;
    end
    if (rd_en) begin
      qd <= query_buffer[idx[cem_pkg::POS_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    p_qg <= qd * gd;
    p_gg <= gd * gd;
    p_qq <= qd * qd;
  end

  cem_score u_score (
    .clk   (clk),
    .rst   (rst),
    .start (score_start),
    .dot   (dot),
    .nq    (nq),
    .ng    (ng),
    .done  (score_done),
    .sim   (sim)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      if (v2) begin
        dot <= dot + cem_pkg::DOT_W'(p_qg);
        ng  <= ng + cem_pkg::NORM_W'(unsigned'(p_gg));
        nq  <= nq + cem_pkg::NORM_W'(unsigned'(p_qq));
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (qry_we && cmd.last) begin
            best     <= cem_pkg::SIM_NONE;
            best_idx <= '0;
            found    <= 1'b0;
            ent      <= '0;
            idx      <= '0;
            dot      <= '0;
            ng       <= '0;
            nq       <= '0;
            state    <= (count == '0) ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          idx <= idx + 1'b1;
          if (idx == (cem_pkg::POS_W+1)'(cem_pkg::VECTOR_LEN - 1)) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (score_start) begin
            state <= ST_SCORE;
          end
        end
        ST_SCORE: begin
          if (score_done) begin
            if (sim > best) begin
              best     <= sim;
              best_idx <= ent[cem_pkg::ENTRY_W-1:0];
              found    <= 1'b1;
            end
            ent <= ent + 1'b1;
            idx <= '0;
            dot <= '0;
            ng  <= '0;
            nq  <= '0;
            state <= (ent + 1'b1 == count) ? ST_FINISH : ST_RUN;
          end
        end
        ST_FINISH: begin
          if (load_out) begin
            m_tdata    <= {best, best_idx};
            m_tuser[0] <= found;
            m_tuser[1] <= found && (best > match_threshold);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (ent < count))
    else $error("search runs past the entry count");

  a_done_in_score: assert property (@(posedge clk) disable iff (rst)
    score_done |-> (state == ST_SCORE))
    else $error("score finished outside the score phase");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!v1 && !v2))
    else $error("command taken while the datapath is busy");

endmodule
`default_nettype wire

FILE: hdl/cosine_embedding_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_embedding_match
// Cosine-similarity nearest-neighbor search over a gallery of embeddings.
// ----------------------------------------------------------------------------
// Gallery and query element beats are taken one per cycle into a four-beat
// queue and written one per cycle while no search runs. A query beat with
// tlast starts a search: for each of the first entry_count entries (at most
// 256), its 512 elements stream through the single read port of the gallery
// memory, the multiply pipeline drains, and the similarity unit forms two
// shift-add products, runs a 16-step root search and applies the sign and
// saturation, or gives the lowest score when either norm is zero. The
// input stalls once the queue is full, and the result beat is held in an
// output register.
// ----------------------------------------------------------------------------
module cosine_embedding_match (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // entry [7:0], position [16:8], value [32:17], zero padding above
  input  wire logic [cem_pkg::IN_DATA_W-1:0]      s_tdata,
  // func [0]
  input  wire logic                               s_tuser,
  input  wire logic                               s_tlast,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // match_index [7:0], best_similarity [23:8]
  output logic [cem_pkg::OUT_DATA_W-1:0]          m_tdata,
  // found [0], matched [1]
  output logic [1:0]                              m_tuser,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  logic [cem_pkg::COUNT_W-1:0]        entry_count;
  logic signed [cem_pkg::SIM_W-1:0]   match_threshold;
  logic                               cmd_valid;
  logic                               pop;
  cem_pkg::cmd_t                      cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      match_threshold <= 16'sd19661;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        match_threshold <= pwdata[15:0];
      end else begin
        entry_count <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {{16{match_threshold[15]}}, match_threshold};
    end else begin
      prdata = {23'b0, entry_count};
    end
  end

  cem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  cem_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .pop             (pop),
    .entry_count     (entry_count),
    .match_threshold (match_threshold),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser)
  );

endmodule
`default_nettype wire
